// ===== src/dwsp_pkg.sv =====
// shared types, register indexes and saturation helpers for the wheel speed controller
`default_nettype none

package dwsp_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned WideW = 64;

  // configuration register indexes
  localparam logic [2:0] REG_KP   = 3'd0;
  localparam logic [2:0] REG_KI   = 3'd1;
  localparam logic [2:0] REG_KD   = 3'd2;
  localparam logic [2:0] REG_TPM  = 3'd3;
  localparam logic [2:0] REG_SPT  = 3'd4;
  localparam logic [2:0] REG_INTV = 3'd5;
  localparam logic [2:0] REG_PWM  = 3'd6;
  localparam logic [2:0] REG_EN   = 3'd7;

  // integral clamp, 0.999 in q16.16
  localparam logic signed [48:0] IntegBound = 49'sd65470;
  localparam logic [16:0]        QOne       = 17'd65536;

  typedef struct packed {
    logic             start;
    logic [WideW-1:0] hi;
    logic [WideW-1:0] lo;
    logic [WideW-1:0] den;
  } div_req_t;

  typedef enum logic [17:0] {
    S_IDLE = 18'h00001,
    S_PREP = 18'h00002,
    S_EMUL = 18'h00004,
    S_D1S  = 18'h00008,
    S_D1W  = 18'h00010,
    S_D2S  = 18'h00020,
    S_D2W  = 18'h00040,
    S_ERR  = 18'h00080,
    S_D3S  = 18'h00100,
    S_D3W  = 18'h00200,
    S_DER  = 18'h00400,
    S_KI   = 18'h00800,
    S_KD   = 18'h01000,
    S_DRV  = 18'h02000,
    S_INT  = 18'h04000,
    S_IK   = 18'h08000,
    S_CLP  = 18'h10000,
    S_FIN  = 18'h20000
  } state_t;

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    mag32 = v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
    if (v > 51'sd2147483647) begin
      sat32 = 32'sh7FFFFFFF;
    end else if (v < -51'sd2147483648) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  function automatic logic signed [31:0] sat_mag(input logic [63:0] mag, input logic neg);
    if (neg) begin
      if (mag >= 64'h80000000) begin
        sat_mag = 32'sh80000000;
      end else begin
        sat_mag = ~mag[31:0] + 32'd1;
      end
    end else if (mag > 64'h7FFFFFFF) begin
      sat_mag = 32'sh7FFFFFFF;
    end else begin
      sat_mag = mag[31:0];
    end
  endfunction

endpackage

`default_nettype wire

// ===== src/dual_wheel_speed_pid_drive.sv =====
// two-wheel speed pid controller with integral clamp and pwm/bridge outputs
//
// input stream: one word per control tick carrying the timer reading, both
// encoder counts, both target speeds and a stop flag. result stream: one word
// per input word with the update flag, both pwm duties, the four bridge pins
// and both drive values. configuration: cfg_we/cfg_index/cfg_data; the user
// writes it only while the block is idle, the block itself does not enforce it.
// one word at a time: in_tready is high only in the idle state. a word that
// runs no update passes through the prep and final states back to idle. a
// word that runs an update takes a time set by the shared divider (three
// divisions per wheel, each cut short when the quotient saturates) and the
// shared multiplier (one product for the elapsed time, five per wheel).
// a new word is taken while the last result still waits in the output
// register; a stalled receiver only holds the sequencer in its final state.
// reset clears the configuration to defaults, all pid state and the output
// valid flag.
`default_nettype none

module dual_wheel_speed_pid_drive (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // timer_now, right_count, left_count, right_target, left_target, stop
  input  wire logic [167:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // updated, right_duty, left_duty, right_pin_fwd, right_pin_rev,
  // left_pin_fwd, left_pin_rev, right_drive, left_drive
  output logic      [103:0] out_tdata,
  input  wire logic         cfg_we,
  input  wire logic   [2:0] cfg_index,
  input  wire logic  [31:0] cfg_data
);

  // configuration
  logic [31:0] kp_r, ki_r, kd_r, tpm_r, spt_r, intv_r;
  logic [15:0] pwm_r;
  logic        en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r   <= '0;
      ki_r   <= '0;
      kd_r   <= '0;
      tpm_r  <= 32'd65536;
      spt_r  <= 32'd1;
      intv_r <= '0;
      pwm_r  <= '0;
      en_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        dwsp_pkg::REG_KP:   kp_r   <= cfg_data;
        dwsp_pkg::REG_KI:   ki_r   <= cfg_data;
        dwsp_pkg::REG_KD:   kd_r   <= cfg_data;
        dwsp_pkg::REG_TPM:  tpm_r  <= cfg_data;
        dwsp_pkg::REG_SPT:  spt_r  <= cfg_data;
        dwsp_pkg::REG_INTV: intv_r <= cfg_data;
        dwsp_pkg::REG_PWM:  pwm_r  <= cfg_data[15:0];
        dwsp_pkg::REG_EN:   en_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // captured input word
  logic        [31:0] now_r;
  logic signed [31:0] rcnt_r, lcnt_r, rtgt_r, ltgt_r;
  logic               stop_r;

  // sequencer and per-item work registers
  dwsp_pkg::state_t   state_r, state_nxt;
  logic               w_r;          // 0 right wheel, 1 left wheel
  logic               upd_r;
  logic        [63:0] e64_r;
  logic        [31:0] e16_r;
  logic               cneg_r, dneg_r, mneg_r;
  logic signed [31:0] err_r, deriv_r;
  logic signed [50:0] acc_r;

  // pid state
  logic        [31:0] last_r;
  logic signed [31:0] rprev_r, lprev_r, rint_r, lint_r, rdrv_r, ldrv_r;
  logic        [15:0] rduty_r, lduty_r;

  // output register
  logic               out_valid_r;
  logic       [103:0] out_data_r;

  // shared units
  dwsp_pkg::div_req_t div_req;
  logic               div_done;
  logic        [63:0] div_quo;
  logic        [31:0] mul_a, mul_b;
  logic               mneg;
  logic        [63:0] mul_p;

  dwsp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quo   (div_quo)
  );

  dwsp_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  // current wheel views
  logic signed [31:0] cur_prev, cur_int, cur_tgt;
  logic        [31:0] cur_cmag;
  logic               cur_cneg;
  logic        [31:0] dt;
  logic signed [48:0] term;
  logic        [47:0] term_mag;
  logic signed [32:0] diff;
  logic        [32:0] dmag;
  logic signed [31:0] speed;
  logic        [31:0] tpm_eff;

  always_comb begin
    cur_prev = w_r ? lprev_r : rprev_r;
    cur_int  = w_r ? lint_r  : rint_r;
    cur_tgt  = w_r ? ltgt_r  : rtgt_r;
    // left wheel is mounted reversed: its count is negated
    cur_cmag = w_r ? dwsp_pkg::mag32(lcnt_r) : dwsp_pkg::mag32(rcnt_r);
    cur_cneg = w_r ? (!lcnt_r[31] && (lcnt_r != 32'sd0)) : rcnt_r[31];
    dt       = now_r - last_r;
    term_mag = mul_p[63:16];
    term     = mneg_r ? -$signed({1'b0, term_mag}) : $signed({1'b0, term_mag});
    diff     = $signed({err_r[31], err_r}) - $signed({cur_prev[31], cur_prev});
    dmag     = diff[32] ? (~diff + 33'd1) : diff;
    speed    = dwsp_pkg::sat_mag(div_quo, cneg_r);
    tpm_eff  = (tpm_r == 32'd0) ? 32'd1 : tpm_r;
  end

  // shared unit operand selection
  always_comb begin
    div_req = '0;
    mul_a   = '0;
    mul_b   = '0;
    mneg    = 1'b0;
    case (state_r)
      dwsp_pkg::S_PREP: begin
        mul_a = dt;
        mul_b = spt_r;
      end
      dwsp_pkg::S_D1S: begin
        div_req.start = 1'b1;
        div_req.hi    = {32'd0, cur_cmag};
        div_req.lo    = '0;
        div_req.den   = e64_r;
      end
      dwsp_pkg::S_D2S: begin
        div_req.start = 1'b1;
        div_req.hi    = '0;
        div_req.lo    = div_quo;
        div_req.den   = {32'd0, tpm_eff};
      end
      dwsp_pkg::S_D3S: begin
        div_req.start = 1'b1;
        div_req.hi    = {63'd0, dmag[32]};
        div_req.lo    = {dmag[31:0], 32'd0};
        div_req.den   = e64_r;
      end
      dwsp_pkg::S_DER: begin
        mul_a = dwsp_pkg::mag32(err_r);
        mul_b = kp_r;
        mneg  = err_r[31];
      end
      dwsp_pkg::S_KI: begin
        mul_a = dwsp_pkg::mag32(cur_int);
        mul_b = ki_r;
        mneg  = cur_int[31];
      end
      dwsp_pkg::S_KD: begin
        mul_a = dwsp_pkg::mag32(deriv_r);
        mul_b = kd_r;
        mneg  = deriv_r[31];
      end
      dwsp_pkg::S_DRV: begin
        mul_a = dwsp_pkg::mag32(err_r);
        mul_b = e16_r;
        mneg  = err_r[31];
      end
      dwsp_pkg::S_IK: begin
        // integral after this update
        mul_a = dwsp_pkg::mag32(cur_int);
        mul_b = ki_r;
        mneg  = cur_int[31];
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dwsp_pkg::S_IDLE: if (in_tvalid) state_nxt = dwsp_pkg::S_PREP;
      dwsp_pkg::S_PREP: begin
        if (en_r && (dt > intv_r)) begin
          state_nxt = dwsp_pkg::S_EMUL;
        end else begin
          state_nxt = dwsp_pkg::S_FIN;
        end
      end
      dwsp_pkg::S_EMUL: state_nxt = dwsp_pkg::S_D1S;
      dwsp_pkg::S_D1S:  state_nxt = dwsp_pkg::S_D1W;
      dwsp_pkg::S_D1W:  if (div_done) state_nxt = dwsp_pkg::S_D2S;
      dwsp_pkg::S_D2S:  state_nxt = dwsp_pkg::S_D2W;
      dwsp_pkg::S_D2W:  if (div_done) state_nxt = dwsp_pkg::S_ERR;
      dwsp_pkg::S_ERR:  state_nxt = dwsp_pkg::S_D3S;
      dwsp_pkg::S_D3S:  state_nxt = dwsp_pkg::S_D3W;
      dwsp_pkg::S_D3W:  if (div_done) state_nxt = dwsp_pkg::S_DER;
      dwsp_pkg::S_DER:  state_nxt = dwsp_pkg::S_KI;
      dwsp_pkg::S_KI:   state_nxt = dwsp_pkg::S_KD;
      dwsp_pkg::S_KD:   state_nxt = dwsp_pkg::S_DRV;
      dwsp_pkg::S_DRV:  state_nxt = dwsp_pkg::S_INT;
      dwsp_pkg::S_INT:  state_nxt = dwsp_pkg::S_IK;
      dwsp_pkg::S_IK:   state_nxt = dwsp_pkg::S_CLP;
      dwsp_pkg::S_CLP:  state_nxt = w_r ? dwsp_pkg::S_FIN : dwsp_pkg::S_D1S;
      dwsp_pkg::S_FIN:  if (!out_valid_r || out_tready) state_nxt = dwsp_pkg::S_IDLE;
      default:          state_nxt = dwsp_pkg::S_IDLE;
    endcase
  end

  // duty and pins from held drives
  logic [31:0] rmag, lmag;
  logic [16:0] rclip, lclip;
  logic [32:0] rprod, lprod;
  logic [15:0] rduty_new, lduty_new;

  always_comb begin
    rmag      = dwsp_pkg::mag32(rdrv_r);
    lmag      = dwsp_pkg::mag32(ldrv_r);
    rclip     = (rmag > 32'd65536) ? dwsp_pkg::QOne : rmag[16:0];
    lclip     = (lmag > 32'd65536) ? dwsp_pkg::QOne : lmag[16:0];
    rprod     = {17'd0, pwm_r} * {16'd0, rclip};
    lprod     = {17'd0, pwm_r} * {16'd0, lclip};
    rduty_new = stop_r ? rduty_r : rprod[31:16];
    lduty_new = stop_r ? lduty_r : lprod[31:16];
  end

  logic signed [50:0] int_sum;
  assign int_sum = $signed({{19{cur_int[31]}}, cur_int}) + $signed({{2{term[48]}}, term});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dwsp_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      w_r         <= 1'b0;
      upd_r       <= 1'b0;
      last_r      <= '0;
      rprev_r     <= '0;
      lprev_r     <= '0;
      rint_r      <= '0;
      lint_r      <= '0;
      rdrv_r      <= '0;
      ldrv_r      <= '0;
      rduty_r     <= '0;
      lduty_r     <= '0;
    end else begin
      state_r <= state_nxt;
      mneg_r  <= mneg;
      // result register loads in the final state, clears when taken
      if ((state_r == dwsp_pkg::S_FIN) && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        dwsp_pkg::S_IDLE: begin
          if (in_tvalid) begin
            now_r  <= in_tdata[31:0];
            rcnt_r <= in_tdata[63:32];
            lcnt_r <= in_tdata[95:64];
            rtgt_r <= in_tdata[127:96];
            ltgt_r <= in_tdata[159:128];
            stop_r <= in_tdata[160];
          end
        end
        dwsp_pkg::S_PREP: begin
          upd_r <= en_r && (dt > intv_r);
          w_r   <= 1'b0;
          if (en_r && (dt > intv_r)) last_r <= now_r;
        end
        dwsp_pkg::S_EMUL: begin
          e64_r <= (mul_p == 64'd0) ? 64'd1 : mul_p;
          e16_r <= (mul_p[63:48] != 16'd0) ? 32'hFFFFFFFF : mul_p[47:16];
        end
        dwsp_pkg::S_D1S: cneg_r <= cur_cneg;
        dwsp_pkg::S_ERR: begin
          err_r <= dwsp_pkg::sat32($signed({{19{cur_tgt[31]}}, cur_tgt})
                                   - $signed({{19{speed[31]}}, speed}));
        end
        dwsp_pkg::S_D3S: begin
          dneg_r <= diff[32];
          if (w_r) lprev_r <= err_r;
          else     rprev_r <= err_r;
        end
        dwsp_pkg::S_DER: deriv_r <= dwsp_pkg::sat_mag(div_quo, dneg_r);
        dwsp_pkg::S_KI:  acc_r <= {{2{term[48]}}, term};
        dwsp_pkg::S_KD:  acc_r <= acc_r + {{2{term[48]}}, term};
        dwsp_pkg::S_DRV: begin
          if (w_r) ldrv_r <= dwsp_pkg::sat32(acc_r + {{2{term[48]}}, term});
          else     rdrv_r <= dwsp_pkg::sat32(acc_r + {{2{term[48]}}, term});
        end
        dwsp_pkg::S_INT: begin
          if (w_r) lint_r <= dwsp_pkg::sat32(int_sum);
          else     rint_r <= dwsp_pkg::sat32(int_sum);
        end
        dwsp_pkg::S_CLP: begin
          // clamp the integral to +-0.999 when i*ki goes beyond +-0.999
          if (term > dwsp_pkg::IntegBound) begin
            if (w_r) lint_r <= 32'sd65470;
            else     rint_r <= 32'sd65470;
          end else if (term < -dwsp_pkg::IntegBound) begin
            if (w_r) lint_r <= -32'sd65470;
            else     rint_r <= -32'sd65470;
          end
          w_r <= 1'b1;
        end
        dwsp_pkg::S_FIN: begin
          if (!out_valid_r || out_tready) begin
            rduty_r     <= rduty_new;
            lduty_r     <= lduty_new;
            out_data_r  <= {3'd0, ldrv_r, rdrv_r,
                            !stop_r && !ldrv_r[31], !stop_r && ldrv_r[31],
                            !stop_r && rdrv_r[31], !stop_r && !rdrv_r[31],
                            lduty_new, rduty_new, upd_r};
          end
        end
        default: ;
      endcase
    end
  end

  assign in_tready  = (state_r == dwsp_pkg::S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// ===== src/dwsp_div.sv =====
// shared restoring divider, 128 by 64 bits, one quotient bit a cycle, saturating
`default_nettype none

module dwsp_div (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire dwsp_pkg::div_req_t  req,
  output logic                     done,
  output logic [63:0]              quo
);

  logic        busy_r;
  logic        done_r;
  logic [5:0]  cnt_r;
  logic [63:0] rem_r, lo_r, den_r, q_r;

  logic        carry, take;
  logic [63:0] shifted, rem_nxt;

  always_comb begin
    carry   = rem_r[63];
    shifted = {rem_r[62:0], lo_r[63]};
    take    = carry || (shifted >= den_r);
    rem_nxt = take ? (shifted - den_r) : shifted;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        if (req.hi >= req.den) begin
          // quotient would not fit
          q_r    <= '1;
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
          rem_r  <= req.hi;
          lo_r   <= req.lo;
          den_r  <= req.den;
          q_r    <= '0;
          cnt_r  <= 6'd63;
        end
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        lo_r  <= {lo_r[62:0], 1'b0};
        q_r   <= {q_r[62:0], take};
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

`default_nettype wire

// ===== src/dwsp_mul.sv =====
// shared 32 by 32 unsigned multiplier with registered product
`default_nettype none

module dwsp_mul (
  input  wire logic        clk,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic      [63:0] p_r
);

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule

`default_nettype wire

// ===== src/dwsp_chk.sv =====
// port-level checker for the wheel speed controller, bound to the top level
`default_nettype none

module dwsp_chk (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tvalid,
  input wire logic         in_tready,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [103:0] out_tdata
);

  // a stalled result word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  // one word at a time: busy right after taking a word
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while busy");

  // bridge pins of one wheel never both high
  a_pins: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[33] && out_tdata[34]) && !(out_tdata[35] && out_tdata[36]))
    else $error("bridge shoot-through");

  // right reverse pin follows a negative right drive
  a_rrev: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[34] |-> out_tdata[68])
    else $error("right reverse pin with nonnegative drive");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind dual_wheel_speed_pid_drive dwsp_chk u_dwsp_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

// ===== tb/dual_wheel_speed_pid_drive_test.sv =====
// self-checking testbench for the two-wheel speed pid controller
`default_nettype none

module dual_wheel_speed_pid_drive_test;

  // input word, last field in the lowest bits
  typedef struct packed {
    logic [6:0]         pad;
    logic               stop;
    logic signed [31:0] left_target;
    logic signed [31:0] right_target;
    logic signed [31:0] left_count;
    logic signed [31:0] right_count;
    logic [31:0]        timer_now;
  } ctl_word_t;

  // result word, last field in the lowest bits
  typedef struct packed {
    logic [2:0]         pad;
    logic signed [31:0] left_drive;
    logic signed [31:0] right_drive;
    logic               left_pin_rev;
    logic               left_pin_fwd;
    logic               right_pin_rev;
    logic               right_pin_fwd;
    logic [15:0]        left_duty;
    logic [15:0]        right_duty;
    logic               updated;
  } drv_word_t;

  localparam int IdleLimit = 20000;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [167:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [103:0] out_tdata;
  logic         cfg_we;
  logic   [2:0] cfg_index;
  logic  [31:0] cfg_data;

  dual_wheel_speed_pid_drive uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor copy of the registers
  logic [31:0] kp, ki, kd, tpm, spt, intv;
  logic [15:0] pwm;
  logic        en;

  // predictor copy of the pid state, index 0 right, 1 left
  logic [31:0]        last_time;
  logic signed [31:0] prev_err[2];
  logic signed [31:0] integ[2];
  logic signed [31:0] drive[2];
  logic [15:0]        duty_hold[2];

  drv_word_t pending_drive_words[$];

  int  sender_pct;
  int  recv_pct;
  int  idle_cycles;
  bit  failed;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------
  // fixed-point predictor
  // ---------------------------------------------------------------

  function automatic logic signed [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // signed result from a magnitude and a sign, saturating
  function automatic logic signed [31:0] signed_of(logic [63:0] m, bit neg);
    if (neg) return (m >= 64'h80000000) ? 32'sh80000000 : -$signed(m[31:0]);
    return (m > 64'h7FFFFFFF) ? 32'sh7FFFFFFF : m[31:0];
  endfunction

  function automatic logic [63:0] abs_of(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  // floor((hi:lo) / den), all ones when it does not fit in 64 bits
  function automatic logic [63:0] quot_sat(logic [63:0] hi, logic [63:0] lo,
                                           logic [63:0] den);
    logic [127:0] num;
    logic [127:0] q;
    if (hi >= den) return '1;
    num = {hi, lo};
    q = num / {64'd0, den};
    return q[63:0];
  endfunction

  // signed q16.16 times unsigned q16.16, truncated toward zero
  function automatic longint gain_mul(logic signed [31:0] a, logic [31:0] g);
    logic [63:0] m;
    m = (abs_of(longint'(a)) * {32'd0, g}) >> 16;
    return a < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic void wheel_pid(int w, longint count, logic signed [31:0] target,
                                    logic [63:0] e64);
    logic [31:0]        tpm_eff;
    logic signed [31:0] speed;
    logic signed [31:0] err;
    logic signed [31:0] deriv;
    longint             diff;
    logic [63:0]        dm;
    logic [63:0]        e16;
    longint             t;
    tpm_eff = (tpm == 0) ? 32'd1 : tpm;
    speed = signed_of(quot_sat(abs_of(count), 64'd0, e64) / {32'd0, tpm_eff}, count < 0);
    err = clip32(longint'(target) - longint'(speed));
    diff = longint'(err) - longint'(prev_err[w]);
    dm = abs_of(diff);
    deriv = signed_of(quot_sat(dm >> 32, dm << 32, e64), diff < 0);
    e16 = e64 >> 16;
    if (e16 > 64'hFFFFFFFF) e16 = 64'hFFFFFFFF;
    prev_err[w] = err;
    // drive uses the integral from before this update
    drive[w] = clip32(gain_mul(err, kp) + gain_mul(integ[w], ki) + gain_mul(deriv, kd));
    integ[w] = clip32(longint'(integ[w]) + gain_mul(err, e16[31:0]));
    t = gain_mul(integ[w], ki);
    if (t > longint'(dwsp_pkg::IntegBound)) integ[w] = dwsp_pkg::IntegBound[31:0];
    else if (t < -longint'(dwsp_pkg::IntegBound)) integ[w] = -dwsp_pkg::IntegBound[31:0];
  endfunction

  function automatic logic [15:0] duty_from(logic signed [31:0] d);
    logic [63:0] m;
    logic [63:0] p;
    m = abs_of(longint'(d));
    if (m > 64'(dwsp_pkg::QOne)) m = 64'(dwsp_pkg::QOne);
    p = ({48'd0, pwm} * m) >> 16;
    return p[15:0];
  endfunction

  function automatic drv_word_t predict_drive_word(ctl_word_t c);
    drv_word_t   r;
    logic [31:0] dt;
    logic [63:0] e64;
    bit          upd;
    dt = c.timer_now - last_time;
    upd = en && (dt > intv);
    if (upd) begin
      e64 = {32'd0, dt} * {32'd0, spt};
      if (e64 == 0) e64 = 64'd1;
      last_time = c.timer_now;
      wheel_pid(0, longint'(c.right_count), c.right_target, e64);
      // left wheel is mounted reversed
      wheel_pid(1, -longint'(c.left_count), c.left_target, e64);
    end
    if (!c.stop) begin
      duty_hold[0] = duty_from(drive[0]);
      duty_hold[1] = duty_from(drive[1]);
    end
    r = '0;
    r.updated       = upd;
    r.right_duty    = duty_hold[0];
    r.left_duty     = duty_hold[1];
    r.right_pin_fwd = !c.stop && drive[0] >= 0;
    r.right_pin_rev = !c.stop && drive[0] < 0;
    r.left_pin_fwd  = !c.stop && drive[1] < 0;
    r.left_pin_rev  = !c.stop && drive[1] >= 0;
    r.right_drive   = drive[0];
    r.left_drive    = drive[1];
    return r;
  endfunction

  // ---------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------

  // one word on the input stream, prediction taken at the accepting edge
  task automatic send_word(ctl_word_t c);
    if (sender_pct > 0 && $urandom_range(0, 99) < sender_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    do @(posedge clk); while (!in_tready);
    pending_drive_words.push_back(predict_drive_word(c));
  endtask

  // hold the sender off until every result has arrived, block back in idle
  task automatic drain;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_drive_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_regs(logic [31:0] kp_v, logic [31:0] ki_v, logic [31:0] kd_v,
                            logic [31:0] tpm_v, logic [31:0] spt_v, logic [31:0] intv_v,
                            logic [15:0] pwm_v, logic en_v);
    logic [31:0] vals[8];
    logic [2:0]  idx[8];
    drain();
    vals = '{kp_v, ki_v, kd_v, tpm_v, spt_v, intv_v, {16'd0, pwm_v}, {31'd0, en_v}};
    idx  = '{dwsp_pkg::REG_KP, dwsp_pkg::REG_KI, dwsp_pkg::REG_KD, dwsp_pkg::REG_TPM,
             dwsp_pkg::REG_SPT, dwsp_pkg::REG_INTV, dwsp_pkg::REG_PWM, dwsp_pkg::REG_EN};
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    kp = kp_v; ki = ki_v; kd = kd_v; tpm = tpm_v;
    spt = spt_v; intv = intv_v; pwm = pwm_v; en = en_v;
    @(posedge clk);
  endtask

  // a word that is due for an update, with content in a sane range
  function automatic ctl_word_t due_word();
    ctl_word_t c;
    c = '0;
    c.timer_now    = last_time + intv + 32'd1 + $urandom_range(0, 20);
    c.right_count  = $signed($urandom_range(0, 400)) - 200;
    c.left_count   = $signed($urandom_range(0, 400)) - 200;
    c.right_target = $signed($urandom_range(0, 262144)) - 131072;
    c.left_target  = $signed($urandom_range(0, 262144)) - 131072;
    c.stop         = ($urandom_range(0, 9) == 0);
    return c;
  endfunction

  function automatic ctl_word_t noise_word();
    ctl_word_t c;
    c = '0;
    c.timer_now    = $urandom;
    c.right_count  = $urandom;
    c.left_count   = $urandom;
    c.right_target = $urandom;
    c.left_target  = $urandom;
    c.stop         = 1'($urandom_range(0, 1));
    return c;
  endfunction

  // ---------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------

  // realistic wheel: 1 ms tick, 10000 ticks per meter, kp 1.0, ki 0.5, kd 1/256
  task automatic set_nominal;
    write_regs(32'h0001_0000, 32'h0000_8000, 32'h0000_0100, 32'd655360000,
               32'd4294967, 32'd9, 16'd1000, 1'b1);
  endtask

  task automatic test_directed;
    ctl_word_t c;
    // disabled after reset: no update, duties from zero drives
    c = due_word();
    c.stop = 1'b0;
    send_word(c);
    set_nominal();
    c = due_word(); c.stop = 1'b0;
    send_word(c);
    // not yet due: dt equal to the interval
    c = due_word(); c.timer_now = last_time + intv;
    send_word(c);
    // count and target extremes
    c = due_word(); c.right_count = 32'sh7FFFFFFF; c.left_count = 32'sh80000000;
    send_word(c);
    c = due_word(); c.right_count = 32'sh80000000; c.left_count = 32'sh7FFFFFFF;
    c.right_target = 32'sh7FFFFFFF; c.left_target = 32'sh80000000;
    send_word(c);
    c = due_word(); c.right_target = 32'sh80000000; c.left_target = 32'sh7FFFFFFF;
    c.stop = 1'b0;
    send_word(c);
    // stop holds duties and lowers every pin, with an update due and without
    c = due_word(); c.stop = 1'b1;
    send_word(c);
    c = due_word(); c.stop = 1'b1; c.timer_now = last_time;
    send_word(c);
    // timer wrap around zero
    c = due_word(); c.timer_now = 32'hFFFF_FFF0;
    send_word(c);
    c = due_word(); c.timer_now = 32'h0000_0010;
    send_word(c);
    c = due_word(); c.right_count = 0; c.left_count = 0; c.stop = 1'b0;
    send_word(c);
    // zero tick length and zero ticks per meter, everything at the top
    write_regs('1, '1, '1, 32'd0, 32'd0, 32'd0, 16'hFFFF, 1'b1);
    for (int i = 0; i < 4; i++) begin
      c = due_word(); c.right_count = 32'sh7FFFFFFF; c.left_count = 32'sh80000000;
      c.stop = (i == 3);
      send_word(c);
    end
    send_word(noise_word());
    // largest tick length and interval: never due, gains zero
    write_regs(32'd0, 32'd0, 32'd0, '1, '1, '1, 16'd0, 1'b1);
    send_word(noise_word());
    send_word(noise_word());
    // interval zero with maximal tick length
    write_regs(32'h0002_0000, 32'h0001_0000, 32'h0000_4000, 32'd1, '1, 32'd0,
               16'd4096, 1'b1);
    send_word(due_word());
    send_word(due_word());
    send_word(noise_word());
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 80) send_word(due_word());
      else send_word(noise_word());
      // sender waits for every result once mid-run
      if (i == n / 2) drain();
    end
  endtask

  task automatic test_random_gains(int n);
    write_regs($urandom_range(0, 32'h0004_0000), $urandom_range(0, 32'h0002_0000),
               $urandom, $urandom_range(1, 32'h1000_0000), $urandom,
               $urandom_range(0, 50), 16'($urandom), 1'b1);
    test_random(n);
  endtask

  // ---------------------------------------------------------------
  // result checker and watchdog
  // ---------------------------------------------------------------

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
      failed = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    drv_word_t exp_w;
    drv_word_t act_w;
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: no handshake for %0d cycles", $time, IdleLimit);
        $display("** dual_wheel_speed_pid_drive: FAILED **");
        $finish;
      end
      if (out_tvalid && out_tready) begin
        act_w = out_tdata;
        if (pending_drive_words.size() == 0) begin
          $display("%0t: unexpected word, expected none, got %h", $time, out_tdata);
          failed = 1'b1;
        end else begin
          exp_w = pending_drive_words.pop_front();
          check_field("updated", 32'(exp_w.updated), 32'(act_w.updated));
          check_field("right_duty", 32'(exp_w.right_duty), 32'(act_w.right_duty));
          check_field("left_duty", 32'(exp_w.left_duty), 32'(act_w.left_duty));
          check_field("right_pin_fwd", 32'(exp_w.right_pin_fwd), 32'(act_w.right_pin_fwd));
          check_field("right_pin_rev", 32'(exp_w.right_pin_rev), 32'(act_w.right_pin_rev));
          check_field("left_pin_fwd", 32'(exp_w.left_pin_fwd), 32'(act_w.left_pin_fwd));
          check_field("left_pin_rev", 32'(exp_w.left_pin_rev), 32'(act_w.left_pin_rev));
          check_field("right_drive", exp_w.right_drive, act_w.right_drive);
          check_field("left_drive", exp_w.left_drive, act_w.left_drive);
        end
      end
    end
    out_tready <= (recv_pct == 0) || ($urandom_range(0, 99) >= recv_pct);
  end

  // ---------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------

  initial begin
    rst_n = 1'b0; in_tvalid = 1'b0; in_tdata = '0; out_tready = 1'b0;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    failed = 1'b0; idle_cycles = 0;
    sender_pct = 9; recv_pct = 75;
    // predictor reset values
    kp = 0; ki = 0; kd = 0; tpm = 32'd65536; spt = 32'd1; intv = 0; pwm = 0; en = 0;
    last_time = 0;
    for (int w = 0; w < 2; w++) begin
      prev_err[w] = 0; integ[w] = 0; drive[w] = 0; duty_hold[w] = 0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    set_nominal();
    test_random(400);
    sender_pct = 75; recv_pct = 9;
    test_random_gains(400);
    sender_pct = 0; recv_pct = 0;
    set_nominal();
    test_random(400);
    test_random_gains(300);
    // disabled phase: no updates, duties follow the held drives
    write_regs(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'd655360000,
               32'd4294967, 32'd9, 16'd777, 1'b0);
    test_random(100);

    drain();
    repeat (20) @(posedge clk);
    if (!failed && pending_drive_words.size() == 0) begin
      $display("** dual_wheel_speed_pid_drive: PASSED **");
    end else begin
      $display("** dual_wheel_speed_pid_drive: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
src/dwsp_pkg.sv
src/dwsp_div.sv
src/dwsp_mul.sv
src/dual_wheel_speed_pid_drive.sv
src/dwsp_chk.sv
tb/dual_wheel_speed_pid_drive_test.sv
